FILE: rtl/sliding_median_filter_core_macros.svh
// Assertion helpers for the filter RTL
`ifndef SLIDING_MEDIAN_FILTER_CORE_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_CORE_MACROS_SVH

// plain property, sampled on clk, off while rst is high
`define SMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication: cons must hold whenever ante holds
`define SMF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/smf_pkg.sv
package smf_pkg;

  localparam int unsigned MAX_WINDOW   = 31;
  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned WINDOW_BITS  = 5;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 5'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RANK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic rotate;
  } cell_ctrl_t;

endpackage

FILE: rtl/smf_cell.sv
module smf_cell #(
  parameter int unsigned SampleBits = 16,
  parameter int unsigned CntBits    = 5,
  parameter int unsigned IdxBits    = 5,
  parameter int unsigned Index      = 0
) (
  input  logic                         clk,
  input  smf_pkg::cell_ctrl_t          ctrl,
  input  logic signed [SampleBits-1:0] value_in,
  input  logic signed [SampleBits-1:0] probe_in,
  input  logic        [IdxBits-1:0]    tag_in,
  input  logic        [CntBits-1:0]    cnt,
  input  logic        [CntBits-1:0]    half,
  output logic signed [SampleBits-1:0] value_out,
  output logic signed [SampleBits-1:0] probe_out,
  output logic        [IdxBits-1:0]    tag_out,
  output logic        [SampleBits-1:0] sel_out,
  output logic                         hit
);
  import smf_pkg::*;

  logic signed [SampleBits-1:0] value;
  logic signed [SampleBits-1:0] probe;
  logic        [IdxBits-1:0]    tag;
  logic        [CntBits-1:0]    rank;
  logic                         in_win;
  logic                         below;
  logic                         count;

  // probe ranks below this cell's sample; ties broken by position
  assign in_win = CntBits'(Index) < cnt;
  assign below  = (probe < value) || ((probe == value) && (tag < IdxBits'(Index)));
  assign count  = in_win && (CntBits'(tag) < cnt) && below;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= value_in;
    end
    if (ctrl.load) begin
      probe <= ctrl.shift ? value_in : value;
      tag   <= IdxBits'(Index);
      rank  <= '0;
    end else if (ctrl.rotate) begin
      probe <= probe_in;
      tag   <= tag_in;
      if (count) begin
        rank <= rank + 1'b1;
      end
    end
  end

  assign value_out = value;
  assign probe_out = probe;
  assign tag_out   = tag;
  assign hit       = in_win && (rank == half);
  assign sel_out   = hit ? value : '0;

endmodule

FILE: rtl/sliding_median_filter_core.sv
// Sliding median filter over blocks of signed samples.
// Input channel: in_valid/in_ready with sample and block_end (last sample
// of a block). Output channel: out_valid/out_ready with median and
// final_res (last result of a block). window_size is set by cfg_we/cfg_wdata,
// and the user must write it only while the filter is idle; the block does
// not enforce this. Zero acts as one, even values are raised by one.
// A row of MaxWindow cells holds the history; each result is found by
// rotating every sample once around the row and counting, per cell, the
// samples ranked below it. A result is loaded into the output register once
// ranking ends; a block-end item emits up to half a window plus one results.
// Until more than half a window of samples is held, items other than a block
// end emit nothing and leave the filter idle for the next sample.
// The next sample may transfer while the last result still waits in the
// output register; a stalled receiver holds the output and, once a new
// result is ready, the rank row waits until the register frees.
// Reset (rst, synchronous) empties the block and sets window_size to 5;
// history contents are left as they are and never read before written.
`include "sliding_median_filter_core_macros.svh"

module sliding_median_filter_core #(
  parameter int unsigned MaxWindow  = smf_pkg::MAX_WINDOW,
  parameter int unsigned SampleBits = smf_pkg::SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic        [smf_pkg::WINDOW_BITS-1:0] cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SampleBits-1:0]          sample,
  input  logic                                  block_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SampleBits-1:0]          median,
  output logic                                  final_res
);
  import smf_pkg::*;

  localparam int unsigned CntBits = $clog2(MaxWindow + 1);
  localparam int unsigned IdxBits = $clog2(MaxWindow);
  localparam int unsigned HiBits  = CntBits + 1;
  localparam int unsigned Cap     = (MaxWindow % 2 == 1) ? MaxWindow : MaxWindow - 1;

  logic [WINDOW_BITS-1:0] window_size;
  state_t                 state, state_next;
  logic [IdxBits-1:0]     step;
  logic [CntBits-1:0]     fill;
  logic [CntBits-1:0]     h_reg;
  logic [CntBits-1:0]     d_reg;
  logic                   is_end;

  logic                   accept;
  logic                   out_load;
  logic                   last;
  logic [6:0]             w_eff;
  logic [CntBits-1:0]     h_new;
  logic [CntBits-1:0]     n_new;
  logic                   has_res;
  logic [CntBits-1:0]     d_init;
  logic [HiBits-1:0]      hi_sum;
  logic [HiBits-1:0]      n_m1;
  logic [HiBits-1:0]      hi;
  logic [CntBits-1:0]     cnt;
  logic [CntBits-1:0]     half;
  cell_ctrl_t             ctrl;

  logic signed [SampleBits-1:0] value_bus [MaxWindow];
  logic signed [SampleBits-1:0] probe_bus [MaxWindow];
  logic        [IdxBits-1:0]    tag_bus   [MaxWindow];
  logic        [SampleBits-1:0] sel_bus   [MaxWindow];
  logic        [MaxWindow-1:0]  hit_vec;
  logic        [SampleBits-1:0] sel_or;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign last     = !is_end || (d_reg == '0);

  always_comb begin
    w_eff = 7'(window_size);
    if (w_eff == 7'd0) begin
      w_eff = 7'd1;
    end
    if (!w_eff[0]) begin
      w_eff = w_eff + 7'd1;
    end
    if (w_eff > 7'(Cap)) begin
      w_eff = 7'(Cap);
    end
    h_new   = CntBits'(w_eff >> 1);
    n_new   = (fill == CntBits'(MaxWindow)) ? fill : fill + 1'b1;
    has_res = block_end || (HiBits'(n_new) >= HiBits'(h_new) + 1'b1);
    if (block_end && (h_new > n_new - 1'b1)) begin
      d_init = n_new - 1'b1;
    end else begin
      d_init = h_new;
    end
  end

  always_comb begin
    hi_sum = HiBits'(d_reg) + HiBits'(h_reg);
    n_m1   = HiBits'(fill) - 1'b1;
    hi     = (hi_sum > n_m1) ? n_m1 : hi_sum;
    cnt    = CntBits'(hi + 1'b1);
    half   = cnt >> 1;
  end

  always_comb begin
    ctrl.shift  = accept;
    ctrl.load   = accept || (out_load && !last);
    ctrl.rotate = (state == S_RANK);
  end

  genvar gi;
  generate
    for (gi = 0; gi < MaxWindow; gi++) begin : g_cell
      logic signed [SampleBits-1:0] v_in;
      if (gi == 0) begin : g_head
        assign v_in = sample;
      end else begin : g_body
        assign v_in = value_bus[gi-1];
      end
      smf_cell #(
        .SampleBits(SampleBits),
        .CntBits   (CntBits),
        .IdxBits   (IdxBits),
        .Index     (gi)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .value_in (v_in),
        .probe_in (probe_bus[(gi + MaxWindow - 1) % MaxWindow]),
        .tag_in   (tag_bus[(gi + MaxWindow - 1) % MaxWindow]),
        .cnt      (cnt),
        .half     (half),
        .value_out(value_bus[gi]),
        .probe_out(probe_bus[gi]),
        .tag_out  (tag_bus[gi]),
        .sel_out  (sel_bus[gi]),
        .hit      (hit_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    sel_or = '0;
    for (int i = 0; i < MaxWindow; i++) begin
      sel_or = sel_or | sel_bus[i];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && has_res) begin
          state_next = S_RANK;
        end
      end
      S_RANK: begin
        if (step == IdxBits'(MaxWindow - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = last ? S_IDLE : S_RANK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
      fill        <= '0;
      step        <= '0;
      h_reg       <= '0;
      d_reg       <= '0;
      is_end      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      if (ctrl.load) begin
        step <= '0;
      end else if (state == S_RANK) begin
        step <= step + 1'b1;
      end
      if (accept) begin
        fill   <= n_new;
        h_reg  <= h_new;
        d_reg  <= d_init;
        is_end <= block_end;
      end else if (out_load) begin
        if (last) begin
          if (is_end) begin
            fill <= '0;
          end
        end else begin
          d_reg <= d_reg - 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median    <= sel_or;
      final_res <= is_end && (d_reg == '0);
    end
  end

  `SMF_ASSERT_IMPL(a_one_rank_hit, state == S_DONE, $onehot(hit_vec), "median rank not unique")
  `SMF_ASSERT_IMPL(a_no_overwrite, out_load, !out_valid || out_ready, "pending result overwritten")
  `SMF_ASSERT(a_fill_range, fill <= CntBits'(MaxWindow), "fill count beyond window depth")
  `SMF_ASSERT_IMPL(a_active_has_fill, state != S_IDLE, fill != '0, "ranking an empty block")

endmodule
